[hdl/cia_pkg.sv]
// Shared types, codes and width helpers for the checked integer ALU.
`default_nettype none
package cia_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int DATA_W    = 64;
  localparam int DIV_STEPS = DATA_W;
  localparam int Q_DEPTH   = 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_NEG = 3'd3,
    OP_SHL = 3'd4,
    OP_SHR = 3'd5,
    OP_DIV = 3'd6,
    OP_MOD = 3'd7
  } op_t;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_OVF  = 2'd1;
  localparam logic [1:0] FAULT_DIV0 = 2'd2;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [2:0]        operand_type;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_bits;
    logic [1:0]        fault;
  } out_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic              sgn;
    logic [1:0]        wsel;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
    logic              a_neg;
    logic              b_neg;
    logic [5:0]        cnt;
    logic              shift_bad;
    logic              b_zero;
    logic              min_neg1;
  } cls_t;

  function automatic logic [6:0] width_of(logic [1:0] ws);
    logic [7:0] w;
    w = 8'd8 << ws;
    if (w > 8'(MAX_WIDTH)) w = 8'(MAX_WIDTH);
    return w[6:0];
  endfunction

  function automatic logic [DATA_W-1:0] mask_of(logic [1:0] ws);
    logic [6:0] w;
    w = width_of(ws);
    if (w >= 7'(DATA_W)) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [DATA_W-1:0] top_of(logic [1:0] ws);
    logic [6:0] w;
    w = width_of(ws);
    return 64'd1 << (w - 7'd1);
  endfunction

endpackage
`default_nettype wire

[hdl/cia_front.sv]
// Front end: take commands, mask operands and classify special cases.
`default_nettype none
module cia_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire cia_pkg::in_t  cmd,
  output logic               busy,
  output logic               cls_valid,
  output cia_pkg::cls_t      cls,
  input  wire logic          cls_ready
);

  logic          fv;
  cia_pkg::cls_t fcls;
  cia_pkg::cls_t c_next;
  logic          accept;
  logic          push;

  logic [63:0] m, top, a, b, sa, sb;
  logic [6:0]  w, wm1;

  assign push   = fv && cls_ready;
  assign busy   = fv && !cls_ready;
  assign accept = start && !busy;

  always_comb begin
    c_next.op   = cia_pkg::op_t'(cmd.opcode);
    c_next.sgn  = !cmd.operand_type[0];
    c_next.wsel = cmd.operand_type[2:1];
    m   = cia_pkg::mask_of(c_next.wsel);
    top = cia_pkg::top_of(c_next.wsel);
    w   = cia_pkg::width_of(c_next.wsel);
    wm1 = w - 7'd1;
    a   = cmd.operand_a & m;
    b   = cmd.operand_b & m;
    c_next.a     = a;
    c_next.b     = b;
    c_next.a_neg = c_next.sgn && ((a & top) != 64'd0);
    c_next.b_neg = c_next.sgn && ((b & top) != 64'd0);
    sa = c_next.a_neg ? (a | ~m) : a;
    sb = c_next.b_neg ? (b | ~m) : b;
    c_next.ma        = c_next.a_neg ? (64'd0 - sa) : a;
    c_next.mb        = c_next.b_neg ? (64'd0 - sb) : b;
    c_next.cnt       = b[5:0] & wm1[5:0];
    c_next.shift_bad = b >= {57'd0, w};
    c_next.b_zero    = b == 64'd0;
    c_next.min_neg1  = (a == top) && (b == m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
    if (accept) begin
      fcls <= c_next;
    end
  end

  assign cls_valid = fv;
  assign cls       = fcls;

endmodule
`default_nettype wire

[hdl/cia_queue.sv]
// Short queue between the front end and the execution pipeline.
`default_nettype none
module cia_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  input  wire cia_pkg::cls_t wr_data,
  output logic               wr_ready,
  output logic               rd_valid,
  output cia_pkg::cls_t      rd_data
);

  cia_pkg::cls_t mem [0:cia_pkg::Q_DEPTH-1];
  logic       wp, rp;
  logic [1:0] count;
  logic       wr, rd;

  assign wr_ready = count < 2'(cia_pkg::Q_DEPTH);
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rp];
  assign wr       = wr_valid && wr_ready;
  // the pipeline behind never stalls: drain every cycle
  assign rd       = rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + 2'(wr) - 2'(rd);
    end
    if (wr) begin
      mem[wp] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[hdl/cia_back.sv]
// Execution pipeline: simple ops, split multiplier and a radix-2 divider.
`default_nettype none
module cia_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire cia_pkg::cls_t in_cls,
  input  wire logic          release_mode,
  output logic               done,
  output cia_pkg::out_t      res
);

  typedef struct packed {
    cia_pkg::op_t op;
    logic         sgn;
    logic [1:0]   wsel;
    logic [63:0]  r;
    logic         ovf;
    logic         a_neg;
    logic         b_neg;
    logic         b_zero;
    logic         min_neg1;
    logic [63:0]  rem;
    logic [63:0]  num;
    logic [63:0]  d;
    logic [63:0]  p00;
    logic [63:0]  p01;
    logic [63:0]  p10;
    logic [63:0]  p11;
    logic [127:0] prod;
  } pipe_t;

  pipe_t pipe [0:cia_pkg::DIV_STEPS];
  logic  vld  [0:cia_pkg::DIV_STEPS];
  pipe_t s0;

  logic [63:0] m0, top0, sa0, ua, ub, sum0;

  // Stage 0: simple ops, partial products and divider setup.
  always_comb begin
    m0   = cia_pkg::mask_of(in_cls.wsel);
    top0 = cia_pkg::top_of(in_cls.wsel);
    sa0  = in_cls.a_neg ? (in_cls.a | ~m0) : in_cls.a;
    ua   = in_cls.sgn ? in_cls.ma : in_cls.a;
    ub   = in_cls.sgn ? in_cls.mb : in_cls.b;
    sum0 = '0;
    s0.op       = in_cls.op;
    s0.sgn      = in_cls.sgn;
    s0.wsel     = in_cls.wsel;
    s0.a_neg    = in_cls.a_neg;
    s0.b_neg    = in_cls.b_neg;
    s0.b_zero   = in_cls.b_zero;
    s0.min_neg1 = in_cls.min_neg1;
    s0.rem      = '0;
    s0.num      = ua;
    s0.d        = ub;
    s0.p00      = 64'(ua[31:0]  * ub[31:0]);
    s0.p01      = 64'(ua[31:0]  * ub[63:32]);
    s0.p10      = 64'(ua[63:32] * ub[31:0]);
    s0.p11      = 64'(ua[63:32] * ub[63:32]);
    s0.prod     = '0;
    s0.r        = '0;
    s0.ovf      = 1'b0;
    unique case (in_cls.op)
      cia_pkg::OP_ADD: begin
        sum0   = (in_cls.a + in_cls.b) & m0;
        s0.r   = sum0;
        s0.ovf = in_cls.sgn ? (((in_cls.a ^ sum0) & (in_cls.b ^ sum0) & top0) != 64'd0)
                            : (sum0 < in_cls.a);
      end
      cia_pkg::OP_SUB: begin
        sum0   = (in_cls.a - in_cls.b) & m0;
        s0.r   = sum0;
        s0.ovf = in_cls.sgn ? (((in_cls.a ^ in_cls.b) & (in_cls.a ^ sum0) & top0) != 64'd0)
                            : (in_cls.b > in_cls.a);
      end
      cia_pkg::OP_NEG: begin
        s0.r   = (64'd0 - in_cls.a) & m0;
        s0.ovf = in_cls.sgn ? (in_cls.a == top0) : (in_cls.a != 64'd0);
      end
      cia_pkg::OP_SHL: begin
        s0.r   = (in_cls.a << in_cls.cnt) & m0;
        s0.ovf = in_cls.shift_bad;
      end
      cia_pkg::OP_SHR: begin
        s0.r   = in_cls.a_neg ? (~((~sa0) >> in_cls.cnt) & m0) : (in_cls.a >> in_cls.cnt);
        s0.ovf = in_cls.shift_bad;
      end
      cia_pkg::OP_MUL: begin
        s0.r   = '0;
      end
      cia_pkg::OP_DIV: begin
        s0.r   = in_cls.a;
        s0.ovf = in_cls.sgn && in_cls.min_neg1;
      end
      cia_pkg::OP_MOD: begin
        s0.r   = '0;
      end
      default: begin
        s0.r   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    pipe[0] <= s0;
  end

  // Divider steps; the first two also finish the multiply.
  for (genvar k = 1; k <= cia_pkg::DIV_STEPS; k++) begin : g_step
    pipe_t       nx;
    logic [64:0] t;
    logic        ge;
    logic [63:0] lo, hi, mk, tp;
    logic        neg;

    always_comb begin
      nx  = pipe[k-1];
      t   = {pipe[k-1].rem, pipe[k-1].num[63]};
      ge  = t >= {1'b0, pipe[k-1].d};
      nx.rem = ge ? 64'(t - {1'b0, pipe[k-1].d}) : t[63:0];
      nx.num = {pipe[k-1].num[62:0], ge};
      lo  = pipe[k-1].prod[63:0];
      hi  = pipe[k-1].prod[127:64];
      mk  = cia_pkg::mask_of(pipe[k-1].wsel);
      tp  = cia_pkg::top_of(pipe[k-1].wsel);
      neg = pipe[k-1].a_neg ^ pipe[k-1].b_neg;
      if (k == 1) begin
        nx.prod = {64'd0, pipe[k-1].p00} + {32'd0, pipe[k-1].p01, 32'd0}
                + {32'd0, pipe[k-1].p10, 32'd0} + {pipe[k-1].p11, 64'd0};
      end
      if (k == 2 && pipe[k-1].op == cia_pkg::OP_MUL) begin
        if (pipe[k-1].sgn) begin
          nx.r   = (neg ? (64'd0 - lo) : lo) & mk;
          nx.ovf = (hi != 64'd0) || ((neg && lo != 64'd0) ? (lo > tp) : (lo > tp - 64'd1));
        end else begin
          nx.r   = lo & mk;
          nx.ovf = (hi != 64'd0) || (lo > mk);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      pipe[k] <= nx;
    end
  end

  // Output stage: finish divide and modulo, fault code, extension.
  pipe_t       pl;
  logic [63:0] mf, tf, rf;
  logic [1:0]  ff;
  logic        is_dm;

  always_comb begin
    pl    = pipe[cia_pkg::DIV_STEPS];
    mf    = cia_pkg::mask_of(pl.wsel);
    tf    = cia_pkg::top_of(pl.wsel);
    rf    = pl.r;
    is_dm = (pl.op == cia_pkg::OP_DIV) || (pl.op == cia_pkg::OP_MOD);
    if (is_dm && !pl.b_zero && !(pl.sgn && pl.min_neg1)) begin
      if (pl.op == cia_pkg::OP_DIV) begin
        rf = ((pl.a_neg ^ pl.b_neg) ? (64'd0 - pl.num) : pl.num) & mf;
      end else begin
        rf = (pl.a_neg ? (64'd0 - pl.rem) : pl.rem) & mf;
      end
    end
    if (is_dm && pl.b_zero) begin
      rf = '0;
    end
    priority if (is_dm && pl.b_zero) begin
      ff = cia_pkg::FAULT_DIV0;
    end else if (pl.ovf && !release_mode) begin
      ff = cia_pkg::FAULT_OVF;
    end else begin
      ff = cia_pkg::FAULT_NONE;
    end
    rf = rf & mf;
    if (pl.sgn && ((rf & tf) != 64'd0)) begin
      rf = rf | ~mf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[cia_pkg::DIV_STEPS];
    end
    res.result_bits <= rf;
    res.fault       <= ff;
  end

endmodule
`default_nettype wire

[hdl/checked_integer_alu.sv]
// Top level of the checked integer ALU: front end, queue and execution pipeline.
`default_nettype none
// Takes one command per cycle (start while busy is low) and returns one result per
// command, in order, on res for a single cycle marked by done; the receiver cannot
// stall. Every command passes the same registers from transfer to done: one front
// register, one queue slot, one setup stage, 64 divider steps (one quotient bit each,
// which also hides the split multiplier) and the output register. busy
// rises only if the queue fills, which does not happen in normal streaming.
// release_mode is written through cfg_we/cfg_data and should change only when idle.
module checked_integer_alu (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire cia_pkg::in_t cmd,
  output logic              busy,
  output logic              done,
  output cia_pkg::out_t     res,
  input  wire logic         cfg_we,
  input  wire logic         cfg_data
);

  logic          release_mode;
  logic          f_valid, f_ready, q_valid;
  cia_pkg::cls_t f_cls, q_cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_mode <= 1'b0;
    end else if (cfg_we) begin
      release_mode <= cfg_data;
    end
  end

  cia_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .cls_valid (f_valid),
    .cls       (f_cls),
    .cls_ready (f_ready)
  );

  cia_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_data  (f_cls),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_data  (q_cls)
  );

  cia_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_cls       (q_cls),
    .release_mode (release_mode),
    .done         (done),
    .res          (res)
  );

  a_no_code3: assert property (@(posedge clk) disable iff (rst)
    done |-> res.fault != 2'd3)
    else $error("invalid fault code");

  a_release_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (done && $past(release_mode)) |-> res.fault != cia_pkg::FAULT_OVF)
    else $error("overflow flagged in release mode");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.fault == cia_pkg::FAULT_DIV0) |-> res.result_bits == 64'd0)
    else $error("divide by zero result not zero");

endmodule
`default_nettype wire

[verif/checked_integer_alu_checker.sv]
// Checker for the checked integer ALU: watches transfers, predicts results and compares them.
`default_nettype none
module checked_integer_alu_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire cia_pkg::in_t  cmd,
  input  wire logic          done,
  input  wire cia_pkg::out_t res,
  input  wire logic          cfg_we,
  input  wire logic          cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic            release_mode;
  cia_pkg::out_t   expected_q[$];

  function automatic logic [63:0] sext(logic [63:0] x, int w);
    logic [63:0] m;
    m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    x &= m;
    if (w < 64 && x[w-1]) x |= ~m;
    return x;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic cia_pkg::out_t alu_predict(cia_pkg::in_t c, logic rel);
    cia_pkg::out_t o;
    logic sgn, ovf, neg;
    int w;
    logic [63:0] m, top, a, b, r, sa, sb, ma, mb, lo;
    logic [127:0] p;
    logic [1:0] f;
    sgn = ~c.operand_type[0];
    w = 8 << c.operand_type[2:1];
    if (w > cia_pkg::MAX_WIDTH) w = cia_pkg::MAX_WIDTH;
    m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    top = 64'd1 << (w - 1);
    a = c.operand_a & m;
    b = c.operand_b & m;
    sa = sext(a, w);
    sb = sext(b, w);
    r = '0;
    f = cia_pkg::FAULT_NONE;
    ovf = 1'b0;
    case (cia_pkg::op_t'(c.opcode))
      cia_pkg::OP_ADD: begin
        r = (a + b) & m;
        ovf = sgn ? (((a ^ r) & (b ^ r) & top) != 0) : (r < a);
      end
      cia_pkg::OP_SUB: begin
        r = (a - b) & m;
        ovf = sgn ? (((a ^ b) & (a ^ r) & top) != 0) : (b > a);
      end
      cia_pkg::OP_MUL: begin
        r = (a * b) & m;
        if (sgn) begin
          ma = mag(sa);
          mb = mag(sb);
          p = {64'd0, ma} * {64'd0, mb};
          lo = p[63:0];
          neg = (sa[63] ^ sb[63]) && lo != 0;
          ovf = p[127:64] != 0 || (neg ? lo > top : lo > top - 1);
        end else begin
          p = {64'd0, a} * {64'd0, b};
          ovf = p[127:64] != 0 || p[63:0] > m;
        end
      end
      cia_pkg::OP_NEG: begin
        r = (-a) & m;
        ovf = sgn ? (a == top) : (a != 0);
      end
      cia_pkg::OP_SHL, cia_pkg::OP_SHR: begin
        ovf = b >= w;
        if (c.opcode == cia_pkg::OP_SHL) r = (a << (b % w)) & m;
        else if (sgn && sa[63]) r = (~((~sa) >> (b % w))) & m;
        else r = a >> (b % w);
      end
      default: begin
        if (b == 0) begin
          f = cia_pkg::FAULT_DIV0;
        end else if (sgn) begin
          if (a == top && b == m) begin
            r = (c.opcode == cia_pkg::OP_DIV) ? a : '0;
            ovf = (c.opcode == cia_pkg::OP_DIV);
          end else begin
            ma = mag(sa);
            mb = mag(sb);
            if (c.opcode == cia_pkg::OP_DIV)
              r = ((sa[63] ^ sb[63]) ? -(ma / mb) : ma / mb) & m;
            else r = (sa[63] ? -(ma % mb) : ma % mb) & m;
          end
        end else begin
          r = (c.opcode == cia_pkg::OP_DIV) ? a / b : a % b;
        end
      end
    endcase
    if (f == cia_pkg::FAULT_NONE && ovf && !rel) f = cia_pkg::FAULT_OVF;
    o.result_bits = sgn ? sext(r, w) : (r & m);
    o.fault = f;
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  assign pending = expected_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    cia_pkg::out_t e;
    if (rst) begin
      release_mode <= 1'b0;
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h/%0d", res.result_bits, res.fault));
        end else begin
          e = expected_q.pop_front();
          if (res.result_bits !== e.result_bits)
            report_mismatch($sformatf("result_bits %h, want %h", res.result_bits,
                                      e.result_bits));
          if (res.fault !== e.fault)
            report_mismatch($sformatf("fault %0d, want %0d", res.fault, e.fault));
        end
      end
      if (start && !busy) expected_q.push_back(alu_predict(cmd, release_mode));
      if (cfg_we) release_mode <= cfg_data;
    end
  end
endmodule
`default_nettype wire

[verif/tb_checked_integer_alu.sv]
// Testbench top for the checked integer ALU: clock, reset, stimulus and verdict.
`default_nettype none
module tb_checked_integer_alu;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 68;
  localparam int WATCHDOG = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cia_pkg::in_t  cmd = '0;
  logic busy, done;
  cia_pkg::out_t res;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  int   errors, pending;
  int   idle_cycles = 0;
  int   burst_left = 0;

  always #5 clk = ~clk;

  checked_integer_alu uut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .res(res), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  checked_integer_alu_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .res(res), .cfg_we(cfg_we), .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("tb_checked_integer_alu NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return 64'd1 << (8 << $urandom_range(0, 3)) - 1;
      3: return (64'd1 << (8 << $urandom_range(0, 3)) - 1) - 1;
      4: return 64'($urandom_range(0, 70));
      5: return -64'($urandom_range(1, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Hold the command until it transfers, then drop start unless another follows.
  task automatic send(logic [2:0] op, logic [2:0] ty, logic [63:0] a, logic [63:0] b,
                      bit more);
    start <= 1'b1;
    cmd <= '{opcode: op, operand_type: ty, operand_a: a, operand_b: b};
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (!more) start <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_mode(logic m);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed();
    int op;
    for (op = 0; op < 8; op++) begin
      send(3'(op), 3'd0, 64'h80, 64'hFF, 1'b1);
      send(3'(op), 3'd7, '1, 64'd0, 1'b1);
      send(3'(op), 3'd6, 64'h8000_0000_0000_0000, '1, 1'b0);
    end
    send(cia_pkg::OP_SHL, 3'd1, 64'hA5, 64'd9, 1'b0);
  endtask

  task automatic random_items(int n);
    int i;
    bit more;
    for (i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left--;
      more = burst_left != 0 && i != n - 1;
      send(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), pick_operand(),
           pick_operand(), more);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed();
    drain();
    set_mode(1'b1);
    directed();
    random_items(300);
    drain();
    set_mode(1'b0);
    random_items(400);
    drain();
    set_mode(1'b1);
    random_items(250);
    drain();
    set_mode(1'b0);
    random_items(250);
    drain();
    if (errors == 0) $display("tb_checked_integer_alu OK");
    else $display("tb_checked_integer_alu NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
